[rtl/hrvs_pkg.sv]
package hrvs_pkg;

	// One stored entry: time it was added, hit count and similarity score.
	typedef struct packed {
		logic [31:0] added;
		logic [31:0] hits;
		logic [15:0] score;
	} entry_t;

	// Command broadcast to every cell of the ring.
	typedef struct packed {
		logic        shift;
		logic        load;
		logic        bump;
		logic [31:0] now;
		logic [15:0] sim;
	} cell_cmd_t;

	localparam int unsigned SCORE_W = 16;

endpackage

[rtl/hit_rate_victim_select.sv]
// Replacement victim selector with score histogram. Each input beat is an
// event (time stamp, optional best-match index, similarity score). The block
// picks as victim the in-use entry with the lowest exact ratio
// (hits+1)/(age+1), lowest index on a tie, loads it with the new time, zero
// hits and the new score, then credits the best match with a saturating hit
// and the higher score. It then sends NUM_BINS output beats, one histogram
// bin each in ascending order, tlast on the final bin. The entries live in
// a ring of cells that rotates past one shared ratio comparator at its head.
// An event takes the victim scan, the victim load, the hit credit and the
// histogram pass, then NUM_BINS output beats: the victim scan passes each
// entry through the comparator as cross products, then compare, and the
// histogram pass rotates the ring once more at one entry per cycle. One
// event is handled at a time; s_tready is high only when the block is idle.
// entry_count is written through cfg_we/cfg_wdata; the user writes it only
// while idle, which the block itself does not enforce. A count of zero acts
// as one and a count above MAX_ENTRIES as MAX_ENTRIES.
module hit_rate_victim_select import hrvs_pkg::*; #(
	parameter int unsigned MAX_ENTRIES = 64,
	parameter int unsigned NUM_BINS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,   // entry_count
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,     // time_now[31:0], match_index[37:32], similarity[53:38]
	input  logic        s_tuser,     // has_match
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,     // victim_index[5:0], bin_index[9:6], bin_count[16:10]
	output logic        m_tlast      // last_bin
);

	localparam int unsigned IW  = $clog2(MAX_ENTRIES);
	localparam int unsigned NW  = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned BW  = $clog2(NUM_BINS);
	localparam int unsigned PW  = SCORE_W + BW + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PROD = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_LOAD = 3'd3;
	localparam logic [2:0] ST_BUMP = 3'd4;
	localparam logic [2:0] ST_HIST = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]    state_q;
	logic [6:0]    entry_count_q;
	logic [NW-1:0] n_q;
	logic [IW-1:0] pos_q;
	logic [31:0]   now_q;
	logic          has_match_q;
	logic [5:0]    midx_q;
	logic [15:0]   sim_q;
	logic [IW-1:0] victim_q;
	logic [31:0]   best_h_q;
	logic [31:0]   best_a_q;
	logic [31:0]   cand_h_q;
	logic [31:0]   cand_a_q;
	logic [65:0]   prod_c_q;
	logic [65:0]   prod_b_q;
	logic [BW-1:0] outb_q;
	logic [6:0]    counts_q [NUM_BINS];

	entry_t    ents [MAX_ENTRIES];
	cell_cmd_t cmd;
	entry_t    head;
	logic [31:0] head_age;
	logic [PW-1:0] bin_prod;
	logic [BW-1:0] head_bin;
	logic          in_use;
	logic [NW-1:0] n_eff;

	assign head     = ents[0];
	assign head_age = now_q - head.added;
	assign in_use   = 32'(pos_q) < 32'(n_q);

	assign bin_prod = PW'(NUM_BINS) * PW'(head.score);
	assign head_bin = ((bin_prod >> SCORE_W) >= PW'(NUM_BINS)) ?
	                  BW'(NUM_BINS - 1) : BW'(bin_prod >> SCORE_W);

	always_comb begin
		if (entry_count_q == 7'd0) begin
			n_eff = NW'(1);
		end else if (32'(entry_count_q) > 32'(MAX_ENTRIES)) begin
			n_eff = NW'(MAX_ENTRIES);
		end else begin
			n_eff = NW'(entry_count_q);
		end
	end

	assign cmd.shift = (state_q == ST_CMP) || (state_q == ST_HIST);
	assign cmd.load  = (state_q == ST_LOAD);
	assign cmd.bump  = (state_q == ST_BUMP) && has_match_q;
	assign cmd.now   = now_q;
	assign cmd.sim   = sim_q;

	// The ring: cell k takes the entry of cell k+1, so entries walk toward
	// the head at cell 0 and come back home after MAX_ENTRIES shifts.
	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_ring
		hrvs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.sel_load (victim_q == IW'(k)),
			.sel_bump (32'(midx_q) == 32'(k)),
			.nxt      (ents[(k + 1) % MAX_ENTRIES]),
			.ent      (ents[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= 7'd64;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			outb_q   <= '0;
			victim_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_PROD;
						pos_q   <= '0;
					end
				end
				ST_PROD: begin
					// Entry 0 seeds the running best; later entries are
					// cross-multiplied against it.
					if (pos_q == '0) begin
						victim_q <= '0;
					end
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (pos_q != '0 && in_use && prod_c_q < prod_b_q) begin
						victim_q <= pos_q;
					end
					if (pos_q == IW'(MAX_ENTRIES - 1)) begin
						state_q <= ST_LOAD;
						pos_q   <= '0;
					end else begin
						state_q <= ST_PROD;
						pos_q   <= pos_q + IW'(1);
					end
				end
				ST_LOAD: state_q <= ST_BUMP;
				ST_BUMP: state_q <= ST_HIST;
				ST_HIST: begin
					if (pos_q == IW'(MAX_ENTRIES - 1)) begin
						state_q <= ST_OUT;
						pos_q   <= '0;
						outb_q  <= '0;
					end else begin
						pos_q <= pos_q + IW'(1);
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						if (outb_q == BW'(NUM_BINS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							outb_q <= outb_q + BW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Event payload, comparator and histogram registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			now_q       <= s_tdata[31:0];
			midx_q      <= s_tdata[37:32];
			sim_q       <= s_tdata[53:38];
			has_match_q <= s_tuser;
			n_q         <= n_eff;
		end
		if (state_q == ST_PROD) begin
			cand_h_q <= head.hits;
			cand_a_q <= head_age;
			prod_c_q <= ({1'b0, head.hits} + 33'd1) * ({1'b0, best_a_q} + 33'd1);
			prod_b_q <= ({1'b0, best_h_q} + 33'd1) * ({1'b0, head_age} + 33'd1);
			if (pos_q == '0) begin
				best_h_q <= head.hits;
				best_a_q <= head_age;
			end
		end
		if (state_q == ST_CMP && pos_q != '0 && in_use && prod_c_q < prod_b_q) begin
			best_h_q <= cand_h_q;
			best_a_q <= cand_a_q;
		end
		for (int b = 0; b < NUM_BINS; b++) begin
			if (state_q == ST_BUMP) begin
				counts_q[b] <= '0;
			end else if (state_q == ST_HIST && in_use && head_bin == BW'(b)) begin
				counts_q[b] <= counts_q[b] + 7'd1;
			end else if (state_q == ST_OUT && m_tready) begin
				counts_q[b] <= (b == NUM_BINS - 1) ? 7'd0 : counts_q[(b + 1) % NUM_BINS];
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tlast  = (outb_q == BW'(NUM_BINS - 1));
	assign m_tdata  = {7'd0, counts_q[0], 4'(outb_q), 6'(victim_q)};

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_PROD && pos_q == '0)
		else $error("accepted event did not start the scan at entry 0");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
		else $error("block not idle after the final bin");

	a_victim_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> 32'(victim_q) < 32'(n_q))
		else $error("victim outside the entries in use");

	a_ring_home: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> $past(state_q) == ST_CMP && $past(pos_q) == IW'(MAX_ENTRIES - 1))
		else $error("victim load before the ring finished a full turn");

endmodule

[rtl/hrvs_cell.sv]
module hrvs_cell import hrvs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  logic      sel_load,
	input  logic      sel_bump,
	input  entry_t    nxt,
	output entry_t    ent
);

	entry_t ent_q;

	// The cell either passes its entry on around the ring, takes a new
	// entry as the victim, or records a hit for the best match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (cmd.shift) begin
			ent_q <= nxt;
		end else if (cmd.load && sel_load) begin
			ent_q.added <= cmd.now;
			ent_q.hits  <= '0;
			ent_q.score <= cmd.sim;
		end else if (cmd.bump && sel_bump) begin
			if (ent_q.hits != '1) begin
				ent_q.hits <= ent_q.hits + 32'd1;
			end
			if (ent_q.score < cmd.sim) begin
				ent_q.score <= cmd.sim;
			end
		end
	end

	assign ent = ent_q;

endmodule
